// ===== hdl/atpm_pkg.sv =====
// ----------------------------------------------------------------------------
// atpm_pkg: shared types and constants of the approximate time pair matcher
// Field widths, register indexes and reset values, the queue command
// codes and the sequencer states.
// ----------------------------------------------------------------------------
package atpm_pkg;

	// field widths
	localparam int TIME_W   = 63;
	localparam int TAG_W    = 16;
	localparam int GAP_W    = 32;
	localparam int ADEPTH_W = 5;
	localparam int CFG_W    = 32;

	// default number of entries per side queue
	localparam int DEF_QUEUE_DEPTH = 16;

	// configuration register indexes and reset values
	localparam logic REG_GAP   = 1'b0;
	localparam logic REG_DEPTH = 1'b1;
	localparam logic [GAP_W-1:0]    GAP_RESET   = 32'd30000000;
	localparam logic [ADEPTH_W-1:0] DEPTH_RESET = 5'd10;

	// commands to a side queue
	typedef enum logic [1:0] {
		Q_HOLD,
		Q_PUSH,
		Q_TRIM,
		Q_DROP
	} q_op_t;

	// matcher sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIM,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_FETCH,
		ST_MID,
		ST_FRONT,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/atpm_ram.sv =====
// ----------------------------------------------------------------------------
// atpm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module atpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/atpm_queue.sv =====
// ----------------------------------------------------------------------------
// atpm_queue: one side queue of the pair matcher
// Circular buffer over a RAM with head pointer and fill count. Supports
// push (dropping the oldest when full), trim to a limit, and dropping the
// first n entries. Reads go by logical index from the front.
// ----------------------------------------------------------------------------
module atpm_queue import atpm_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_op_t             op,
	input  logic [CNT_W-1:0]  drop_n,
	input  logic [CNT_W-1:0]  depth_lim,
	input  logic [TIME_W-1:0] wr_time,
	input  logic [TAG_W-1:0]  wr_tag,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [CNT_W-1:0]  fill,
	output logic [TIME_W-1:0] rd_time,
	output logic [TAG_W-1:0]  rd_tag
);

	localparam int SUM_W = CNT_W + 1;

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] head_d;
	logic [CNT_W-1:0] fill_d;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	logic             full;
	logic [TIME_W+TAG_W-1:0] rdata;

	// pointer add with wrap; both operands stay at or below DEPTH
	function automatic logic [IDX_W-1:0] wrap_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = a + b;
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign raddr = wrap_add(SUM_W'(head_q), SUM_W'(rd_idx));

	// pointer and fill update per command
	always_comb begin
		head_d = head_q;
		fill_d = fill_q;
		we     = 1'b0;
		waddr  = wrap_add(SUM_W'(head_q), SUM_W'(fill_q));
		case (op)
			Q_PUSH: begin
				we = 1'b1;
				if (full) begin
					// oldest slot is overwritten, front moves up by one
					waddr  = head_q;
					head_d = wrap_add(SUM_W'(head_q), SUM_W'(1));
				end else begin
					fill_d = fill_q + CNT_W'(1);
				end
			end
			Q_TRIM: begin
				if (fill_q > depth_lim) begin
					head_d = wrap_add(SUM_W'(head_q), SUM_W'(fill_q - depth_lim));
					fill_d = depth_lim;
				end
			end
			Q_DROP: begin
				if (drop_n >= fill_q) begin
					fill_d = '0;
				end else begin
					head_d = wrap_add(SUM_W'(head_q), SUM_W'(drop_n));
					fill_d = fill_q - drop_n;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			head_q <= head_d;
			fill_q <= fill_d;
		end
	end

	// entry storage: time in the upper bits, tag in the lower
	atpm_ram #(
		.WIDTH(TIME_W + TAG_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({wr_time, wr_tag}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign fill    = fill_q;
	assign rd_time = rdata[TIME_W+TAG_W-1:TAG_W];
	assign rd_tag  = rdata[TAG_W-1:0];

endmodule

// ===== hdl/approx_time_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// approx_time_pair_matcher: pairs left and right observations by time
// Keeps a bounded queue per side, searches all pairs for the closest one,
// emits pairs within the gap limit with their midpoint time, and drops
// stale front entries.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   obs     | in        | obs_valid / obs_stall  | from_left, stamp_ns, item_tag
//   pair    | out       | pair_valid / pair_stall| left_tag, right_tag, left_time,
//           |           |                        | right_time, mid_time, last_pair
//   cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// Sequence: accept and trim, then per search round check, scan, drain,
// evaluate and front drop, or fetch and midpoint when a pair is taken; the
// scan covers all L*R pairs, with L, R the side fills; then finish. One
// shared subtract unit scans one pair per cycle.
// Reset empties both queues; no clearing pass is needed. A stalled pair output
// holds the sequencer only while output and pending registers are both full.
// ----------------------------------------------------------------------------
module approx_time_pair_matcher import atpm_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// observation input
	input  logic              obs_valid,
	output logic              obs_stall,
	input  logic              from_left,
	input  logic [TIME_W-1:0] stamp_ns,
	input  logic [TAG_W-1:0]  item_tag,
	// pair output
	output logic              pair_valid,
	input  logic              pair_stall,
	output logic [TAG_W-1:0]  left_tag,
	output logic [TAG_W-1:0]  right_tag,
	output logic [TIME_W-1:0] left_time,
	output logic [TIME_W-1:0] right_time,
	output logic [TIME_W-1:0] mid_time,
	output logic              last_pair
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LIM_W = (CNT_W > ADEPTH_W) ? CNT_W : ADEPTH_W;

	// configuration registers
	logic [GAP_W-1:0]    gap_q;
	logic [ADEPTH_W-1:0] adepth_q;
	logic [CNT_W-1:0]    depth_lim;

	// sequencer
	state_t state_q, state_d;
	logic   side_q;

	// queue interface
	q_op_t             l_op, r_op;
	logic [CNT_W-1:0]  l_n, r_n;
	logic [IDX_W-1:0]  l_idx, r_idx;
	logic [CNT_W-1:0]  l_fill, r_fill;
	logic [TIME_W-1:0] l_rd_time, r_rd_time;
	logic [TAG_W-1:0]  l_rd_tag, r_rd_tag;

	// scan counters and pipeline
	logic [IDX_W-1:0]  i_q, j_q;
	logic              row_end, scan_end;
	logic              v_s1, v_s2;
	logic [IDX_W-1:0]  il_s1, jr_s1, il_s2, jr_s2;
	logic [TIME_W-1:0] diff_s2;
	logic              have_q;
	logic [TIME_W-1:0] best_q;
	logic [IDX_W-1:0]  bl_q, br_q;
	logic              take;

	// shared abs-difference unit
	logic              du_ge;
	logic [TIME_W-1:0] du_diff;

	// matched pair
	logic [TIME_W-1:0] lt_q, rt_q, diff_q, mid;
	logic [TAG_W-1:0]  ltag_q, rtag_q;
	logic              ge_q;

	// stale front checks
	logic              stale_l, stale_r;

	// pending pair and output register
	logic              pend_valid_q;
	logic [TIME_W-1:0] pend_lt_q, pend_rt_q, pend_mid_q;
	logic [TAG_W-1:0]  pend_ltag_q, pend_rtag_q;
	logic              out_valid_q, out_last_q;
	logic [TIME_W-1:0] out_lt_q, out_rt_q, out_mid_q;
	logic [TAG_W-1:0]  out_ltag_q, out_rtag_q;
	logic              out_free, out_load, out_last, pend_load, pend_clear;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= GAP_RESET;
			adepth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAP:   gap_q    <= cfg_data[GAP_W-1:0];
				REG_DEPTH: adepth_q <= cfg_data[ADEPTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective depth: zero acts as one, capped at the queue size
	always_comb begin
		if (adepth_q == '0) begin
			depth_lim = CNT_W'(1);
		end else if (LIM_W'(adepth_q) > LIM_W'(QUEUE_DEPTH)) begin
			depth_lim = CNT_W'(QUEUE_DEPTH);
		end else begin
			depth_lim = CNT_W'(adepth_q);
		end
	end

	// side queues
	atpm_queue #(.DEPTH(QUEUE_DEPTH)) u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (l_op),
		.drop_n   (l_n),
		.depth_lim(depth_lim),
		.wr_time  (stamp_ns),
		.wr_tag   (item_tag),
		.rd_idx   (l_idx),
		.fill     (l_fill),
		.rd_time  (l_rd_time),
		.rd_tag   (l_rd_tag)
	);

	atpm_queue #(.DEPTH(QUEUE_DEPTH)) u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (r_op),
		.drop_n   (r_n),
		.depth_lim(depth_lim),
		.wr_time  (stamp_ns),
		.wr_tag   (item_tag),
		.rd_idx   (r_idx),
		.fill     (r_fill),
		.rd_time  (r_rd_time),
		.rd_tag   (r_rd_tag)
	);

	// shared subtract unit on the RAM read data: |right - left|
	assign du_ge   = (r_rd_time >= l_rd_time);
	assign du_diff = du_ge ? (r_rd_time - l_rd_time) : (l_rd_time - r_rd_time);

	// scan position and decisions
	assign row_end  = ((CNT_W'(j_q) + CNT_W'(1)) == r_fill);
	assign scan_end = row_end && ((CNT_W'(i_q) + CNT_W'(1)) == l_fill);
	assign take     = (best_q <= TIME_W'(gap_q));
	assign stale_l  = (({1'b0, l_rd_time} + 64'(gap_q)) < {1'b0, r_rd_time});
	assign stale_r  = (({1'b0, r_rd_time} + 64'(gap_q)) < {1'b0, l_rd_time});

	// midpoint: left plus or minus half the difference
	assign mid = ge_q ? (lt_q + (diff_q >> 1)) : (lt_q - (diff_q >> 1));

	assign out_free  = !out_valid_q || !pair_stall;
	assign obs_stall = (state_q != ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and queue commands
	always_comb begin
		state_d    = state_q;
		l_op       = Q_HOLD;
		r_op       = Q_HOLD;
		l_n        = CNT_W'(1);
		r_n        = CNT_W'(1);
		l_idx      = i_q;
		r_idx      = j_q;
		out_load   = 1'b0;
		out_last   = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (obs_valid) begin
					if (from_left) begin
						l_op = Q_PUSH;
					end else begin
						r_op = Q_PUSH;
					end
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (side_q) begin
					l_op = Q_TRIM;
				end else begin
					r_op = Q_TRIM;
				end
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (l_fill != '0 && r_fill != '0) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (take) begin
					l_idx   = bl_q;
					r_idx   = br_q;
					state_d = ST_FETCH;
				end else begin
					l_idx   = '0;
					r_idx   = '0;
					state_d = ST_FRONT;
				end
			end
			ST_FETCH: begin
				state_d = ST_MID;
			end
			ST_MID: begin
				// the older pending pair moves out before this one is held
				if (!pend_valid_q || out_free) begin
					out_load  = pend_valid_q;
					pend_load = 1'b1;
					l_op      = Q_DROP;
					r_op      = Q_DROP;
					l_n       = CNT_W'(bl_q) + CNT_W'(1);
					r_n       = CNT_W'(br_q) + CNT_W'(1);
					state_d   = ST_CHECK;
				end
			end
			ST_FRONT: begin
				if (stale_l) begin
					l_op    = Q_DROP;
					state_d = ST_CHECK;
				end else if (stale_r) begin
					r_op    = Q_DROP;
					state_d = ST_CHECK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// last pending pair goes out marked as final
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last   = 1'b1;
					pend_clear = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q       <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			have_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && obs_valid) begin
				side_q <= from_left;
			end

			// scan counters: right index inner, left index outer
			if (state_q == ST_CHECK) begin
				i_q    <= '0;
				j_q    <= '0;
				have_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (row_end) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			if (v_s2) begin
				have_q <= 1'b1;
			end

			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!pair_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan pipeline and best-pair tracking
	always_ff @(posedge clk) begin
		il_s1   <= i_q;
		jr_s1   <= j_q;
		il_s2   <= il_s1;
		jr_s2   <= jr_s1;
		diff_s2 <= du_diff;
		// strict compare keeps the earliest pair on ties
		if (v_s2 && (!have_q || diff_s2 < best_q)) begin
			best_q <= diff_s2;
			bl_q   <= il_s2;
			br_q   <= jr_s2;
		end
	end

	// matched pair capture, pending pair and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			lt_q   <= l_rd_time;
			rt_q   <= r_rd_time;
			ltag_q <= l_rd_tag;
			rtag_q <= r_rd_tag;
			diff_q <= du_diff;
			ge_q   <= du_ge;
		end
		if (out_load) begin
			out_lt_q   <= pend_lt_q;
			out_rt_q   <= pend_rt_q;
			out_mid_q  <= pend_mid_q;
			out_ltag_q <= pend_ltag_q;
			out_rtag_q <= pend_rtag_q;
			out_last_q <= out_last;
		end
		if (pend_load) begin
			pend_lt_q   <= lt_q;
			pend_rt_q   <= rt_q;
			pend_mid_q  <= mid;
			pend_ltag_q <= ltag_q;
			pend_rtag_q <= rtag_q;
		end
	end

	assign pair_valid = out_valid_q;
	assign left_tag   = out_ltag_q;
	assign right_tag  = out_rtag_q;
	assign left_time  = out_lt_q;
	assign right_time = out_rt_q;
	assign mid_time   = out_mid_q;
	assign last_pair  = out_last_q;

	// checks
	a_no_pending_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_IDLE && pend_valid_q))
		else $error("pending pair left behind at idle");

	a_pair_within_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MID) |-> (diff_q <= TIME_W'(gap_q)))
		else $error("pair emitted beyond gap limit");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(l_fill <= CNT_W'(QUEUE_DEPTH)) && (r_fill <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue fill beyond depth");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM) |-> ((side_q && l_fill != '0) || (!side_q && r_fill != '0)))
		else $error("push left pushed side empty");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for approx_time_pair_matcher
// Left and right observations go in through the obs channel. A behavioral
// matcher predicts the pairs each transfer causes. Every pair that leaves the
// block is compared field by field with the oldest prediction. A directed
// table comes first, then random phases under several gap and depth settings.
// Idle and stall patterns vary from phase to phase, and one long output
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench import atpm_pkg::*; ();

	localparam int QD            = DEF_QUEUE_DEPTH;
	localparam int SETTLE_CYCLES = 9000;   // worst case: at most 31 search rounds
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 10_000_000;
	localparam int RANDOM_ITEMS  = 20;
	localparam int BURST_ITEMS   = 18;
	localparam int PLAN_ROWS     = 26;
	localparam logic [TIME_W-1:0] MAX_STAMP = {TIME_W{1'b1}};

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [TAG_W-1:0]  tag;
	} obs_entry_t;

	typedef struct packed {
		logic [TAG_W-1:0]  left_tag;
		logic [TAG_W-1:0]  right_tag;
		logic [TIME_W-1:0] left_time;
		logic [TIME_W-1:0] right_time;
		logic [TIME_W-1:0] mid_time;
		logic              last_pair;
	} pair_t;

	typedef enum logic {ROW_OBS, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

	// sel: from_left for observations, register index for writes
	typedef struct packed {
		row_kind_t         kind;
		logic              sel;
		logic [TIME_W-1:0] value;
		logic [TAG_W-1:0]  tag;
		row_check_t        check;
		logic [TAG_W-1:0]  l_tag;
		logic [TAG_W-1:0]  r_tag;
		logic [TIME_W-1:0] l_time;
		logic [TIME_W-1:0] r_time;
		logic [TIME_W-1:0] m_time;
	} plan_row_t;

	// directed table
	plan_row_t plan [PLAN_ROWS] = '{
		// reset settings: simple pair, then pairs at the top of the time range
		'{ROW_OBS, 1'b1, 63'd1000, 16'h0001, CHK_NONE, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd2000, 16'h0002, CHK_ONE,
			16'h0001, 16'h0002, 63'd1000, 63'd2000, 63'd1500},
		'{ROW_OBS, 1'b0, MAX_STAMP, 16'hFFFF, CHK_NONE, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, MAX_STAMP - 1, 16'h0000, CHK_ONE,
			16'h0000, 16'hFFFF, MAX_STAMP - 1, MAX_STAMP, MAX_STAMP - 1},
		// left later than right: midpoint rounds toward the left time
		'{ROW_OBS, 1'b0, 63'd100, 16'h00AA, CHK_NONE, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, 63'd101, 16'h5555, CHK_ONE,
			16'h5555, 16'h00AA, 63'd101, 63'd100, 63'd101},
		// stale left front dropped, then stale right front dropped
		'{ROW_OBS, 1'b1, 63'd0, 16'h0010, CHK_NONE, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd50_000_000, 16'h0011, CHK_NONE, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, 63'd100_000_000, 16'h0012, CHK_NONE, '0, '0, '0, '0, '0},
		// zero gap: exact matches only, ties on either side
		'{ROW_CFG, REG_GAP, 63'd0, '0, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd100_000_000, 16'h0020, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, 63'd500, 16'h0021, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, 63'd500, 16'h0022, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd500, 16'h0023, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd501, 16'h0024, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd700, 16'h0025, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, 63'd700, 16'h0026, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd900, 16'h0027, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd900, 16'h0028, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, 63'd900, 16'h0029, CHK_MODEL, '0, '0, '0, '0, '0},
		// widest gap, depth 0 acting as 1
		'{ROW_CFG, REG_GAP, 63'hFFFF_FFFF, '0, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_CFG, REG_DEPTH, 63'd0, '0, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd5, 16'h0030, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b0, 63'd6, 16'h0031, CHK_MODEL, '0, '0, '0, '0, '0},
		'{ROW_OBS, 1'b1, MAX_STAMP, 16'h0032, CHK_NONE, '0, '0, '0, '0, '0},
		// depth above the queue size acts as the queue size
		'{ROW_CFG, REG_DEPTH, 63'd31, '0, CHK_MODEL, '0, '0, '0, '0, '0}
	};

	// random phase settings
	localparam logic [CFG_W-1:0] PHASE_GAP [6] =
		'{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd30_000_000, 32'd50};
	localparam logic [CFG_W-1:0] PHASE_DEPTH [6] =
		'{32'd16, 32'd1, 32'd31, 32'hFFFF_FFE4, 32'd10, 32'd2};

	// DUT ports
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic              cfg_index  = 1'b0;
	logic [CFG_W-1:0]  cfg_data   = '0;
	logic              obs_valid  = 1'b0;
	logic              obs_stall;
	logic              from_left  = 1'b0;
	logic [TIME_W-1:0] stamp_ns   = '0;
	logic [TAG_W-1:0]  item_tag   = '0;
	logic              pair_valid;
	logic              pair_stall = 1'b0;
	logic [TAG_W-1:0]  left_tag;
	logic [TAG_W-1:0]  right_tag;
	logic [TIME_W-1:0] left_time;
	logic [TIME_W-1:0] right_time;
	logic [TIME_W-1:0] mid_time;
	logic              last_pair;

	// matcher state as predicted
	logic [GAP_W-1:0]    gap_ns    = GAP_RESET;
	logic [ADEPTH_W-1:0] depth_reg = DEPTH_RESET;
	obs_entry_t          left_q[$];
	obs_entry_t          right_q[$];
	pair_t               fresh_pairs[$];   // pairs caused by the latest transfer
	pair_t               pairs_due[$];     // predicted pairs not yet seen
	pair_t               arrived_due;

	// run bookkeeping
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_request  = 1'b0;
	int          hold_left     = 0;
	bit          settled       = 1'b1;
	int          mismatches    = 0;
	int          obs_sent      = 0;
	int          pairs_seen    = 0;
	int          reg_writes    = 0;
	int unsigned cycle_count   = 0;

	approx_time_pair_matcher u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.obs_valid  (obs_valid),
		.obs_stall  (obs_stall),
		.from_left  (from_left),
		.stamp_ns   (stamp_ns),
		.item_tag   (item_tag),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.left_tag   (left_tag),
		.right_tag  (right_tag),
		.left_time  (left_time),
		.right_time (right_time),
		.mid_time   (mid_time),
		.last_pair  (last_pair)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] stamp_dist(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	// Push one observation, then pair and prune until the queues settle.
	function automatic void match_observation(input logic to_left,
			input logic [TIME_W-1:0] t, input logic [TAG_W-1:0] tag);
		int                depth;
		int                bl;
		int                br;
		int                i;
		int                j;
		logic [63:0]       best;
		logic [63:0]       d;
		logic [TIME_W-1:0] lt;
		logic [TIME_W-1:0] rt;
		logic [TIME_W-1:0] mid;
		pair_t             p;
		obs_entry_t        e;

		depth = (depth_reg == 0) ? 1 : ((depth_reg > QD) ? QD : int'(depth_reg));
		fresh_pairs.delete();
		e.stamp = t;
		e.tag   = tag;

		// only the side that takes the push is trimmed
		if (to_left) begin
			while (left_q.size() >= QD) left_q.delete(0);
			left_q = {left_q, e};
			while (left_q.size() > depth) left_q.delete(0);
		end else begin
			while (right_q.size() >= QD) right_q.delete(0);
			right_q = {right_q, e};
			while (right_q.size() > depth) right_q.delete(0);
		end

		while (left_q.size() > 0 && right_q.size() > 0) begin
			// closest pair, first found wins ties
			bl = 0;
			br = 0;
			best = stamp_dist(left_q[0].stamp, right_q[0].stamp);
			for (i = 0; i < left_q.size(); i++)
				for (j = 0; j < right_q.size(); j++) begin
					d = stamp_dist(left_q[i].stamp, right_q[j].stamp);
					if (d < best) begin
						best = d;
						bl = i;
						br = j;
					end
				end

			if (best <= {32'd0, gap_ns}) begin
				lt = left_q[bl].stamp;
				rt = right_q[br].stamp;
				mid = (rt >= lt) ? lt + ((rt - lt) >> 1) : lt - ((lt - rt) >> 1);
				p = '{left_tag: left_q[bl].tag, right_tag: right_q[br].tag,
					left_time: lt, right_time: rt, mid_time: mid, last_pair: 1'b0};
				if (fresh_pairs.size() < QD) fresh_pairs = {fresh_pairs, p};
				// matched entries go, along with everything older
				repeat (bl + 1) left_q.delete(0);
				repeat (br + 1) right_q.delete(0);
			end else if ({1'b0, left_q[0].stamp} + 64'(gap_ns) < {1'b0, right_q[0].stamp}) begin
				left_q.delete(0);
			end else if ({1'b0, right_q[0].stamp} + 64'(gap_ns) < {1'b0, left_q[0].stamp}) begin
				right_q.delete(0);
			end else begin
				break;
			end
		end

		if (fresh_pairs.size() != 0) fresh_pairs[fresh_pairs.size() - 1].last_pair = 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("pair field %s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// One obs transfer, with a random idle gap in front; valid stays up afterward.
	task automatic send_obs(input logic to_left, input logic [TIME_W-1:0] t,
			input logic [TAG_W-1:0] tag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			obs_valid <= 1'b0;
			@(posedge clk);
		end
		obs_valid <= 1'b1;
		from_left <= to_left;
		stamp_ns  <= t;
		item_tag  <= tag;
		do @(posedge clk); while (obs_stall);
		settled = 1'b0;
		obs_sent++;
		match_observation(to_left, t, tag);
		foreach (fresh_pairs[k]) pairs_due = {pairs_due, fresh_pairs[k]};
	endtask

	// Stop sending, wait out every predicted pair, then the search tail.
	task automatic settle_block();
		obs_valid <= 1'b0;
		while (pairs_due.size() != 0) @(posedge clk);
		if (!settled) repeat (SETTLE_CYCLES) @(posedge clk);
		settled = 1'b1;
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_GAP)
			gap_ns = v;
		else
			depth_reg = v[ADEPTH_W-1:0];
		reg_writes++;
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			pair_stall <= 1'b1;
			hold_left--;
		end else begin
			pair_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// pair checker
	always @(posedge clk) begin
		if (arst_n && pair_valid === 1'b1 && pair_stall == 1'b0) begin
			if (pairs_due.size() == 0) begin
				$error("unexpected pair: left_tag %0d right_tag %0d", left_tag, right_tag);
				mismatches++;
			end else begin
				arrived_due = pairs_due[0];
				pairs_due.delete(0);
				pairs_seen++;
				check_field("left_tag", TIME_W'(arrived_due.left_tag), TIME_W'(left_tag));
				check_field("right_tag", TIME_W'(arrived_due.right_tag), TIME_W'(right_tag));
				check_field("left_time", arrived_due.left_time, left_time);
				check_field("right_time", arrived_due.right_time, right_time);
				check_field("mid_time", arrived_due.mid_time, mid_time);
				check_field("last_pair", TIME_W'(arrived_due.last_pair), TIME_W'(last_pair));
			end
		end
	end

	// stimulus
	initial begin
		int                ph;
		int                n;
		int unsigned       pick;
		logic              side;
		logic [TIME_W-1:0] last_stamp;
		logic [TIME_W-1:0] t;
		logic [31:0]       spread;
		pair_t             typed;

		side = 1'b0;
		last_stamp = 63'd1_000_000_000;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		send_idle_pct = 10;
		recv_idle_pct = 45;
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				write_reg(plan[r].sel, plan[r].value[CFG_W-1:0]);
			end else begin
				send_obs(plan[r].sel, plan[r].value, plan[r].tag);
				typed = '{left_tag: plan[r].l_tag, right_tag: plan[r].r_tag,
					left_time: plan[r].l_time, right_time: plan[r].r_time,
					mid_time: plan[r].m_time, last_pair: 1'b1};
				if ((plan[r].check == CHK_NONE && fresh_pairs.size() != 0) ||
						(plan[r].check == CHK_ONE &&
						(fresh_pairs.size() != 1 || fresh_pairs[0] !== typed))) begin
					$error("table row %0d: prediction gives %0d pairs, not the listed result",
						r, fresh_pairs.size());
					mismatches++;
				end
			end
		end

		// random phases
		for (ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 10 : ((ph < 4) ? 45 : 0);
			recv_idle_pct = (ph < 2) ? 45 : ((ph < 4) ? 10 : 0);
			write_reg(REG_GAP, (ph == 3) ? $urandom : PHASE_GAP[ph]);
			write_reg(REG_DEPTH, PHASE_DEPTH[ph]);
			if (ph == 2) hold_request = 1'b1;
			spread = (gap_ns > 32'd2_000_000) ? 32'd2_000_000 : gap_ns;

			for (n = 0; n < RANDOM_ITEMS; n++) begin
				// mostly alternating sides near a drifting time, some wild stamps
				pick = $urandom_range(0, 15);
				if ($urandom_range(0, 3) != 0) side = ~side;
				if (pick == 0)
					t = TIME_W'({$urandom, $urandom});
				else if (pick <= 5)
					t = last_stamp;
				else
					t = last_stamp + TIME_W'($urandom_range(0, 2 * spread));
				last_stamp = t;
				send_obs(side, t, TAG_W'($urandom));
			end

			// fill the left queue past its size before depth drops to 1
			if (ph == 0)
				for (n = 0; n < BURST_ITEMS; n++) begin
					last_stamp = last_stamp + 63'd10_000_000;
					send_obs(1'b1, last_stamp, TAG_W'($urandom));
				end
		end

		settle_block();
		$display("Run covered %0d observations, %0d checked pairs, %0d register writes,",
			obs_sent, pairs_seen, reg_writes);
		$display("gaps from 0 to full range, depths 0 to 31, with stalls and a long hold-off.");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== approx_time_pair_matcher.f =====
hdl/atpm_pkg.sv
hdl/atpm_ram.sv
hdl/atpm_queue.sv
hdl/approx_time_pair_matcher.sv
verif/testbench.sv
